// ===== src/deq_pkg.sv =====
// Shared types and constants for the indexed deque engine.
`default_nettype none
package deq_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int DATA_W = 32;
  localparam int OCC_W = 9;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ_AT    = 3'd4,
    MODE_WRITE_AT   = 3'd5,
    MODE_SEARCH     = 3'd6,
    MODE_NONE       = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SRCH,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== src/indexed_deque_engine_unit.sv =====
// Top level of the indexed deque engine: command sequencer around the entry store.
// Steps, request accepted to result valid: push, write, mode seven and errors go straight to the
// result state; pop and read pass through the read state; search walks the entries, up to the occupancy.
// A new request is taken only once the last result has been loaded; search reads one entry per cycle
// through the single read port of the store, so its length sets the average rate.
// Reset (rst, synchronous): front pointer and count go to zero, no result pending;
// the store has no clearing pass and its contents stay undefined until written.
`default_nettype none
module indexed_deque_engine_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [2:0]                 mode,
  input  wire logic        [7:0]                 position,
  input  wire logic signed [deq_pkg::DATA_W-1:0] data_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed      [deq_pkg::DATA_W-1:0] data_out,
  output logic                                   found,
  output logic             [1:0]                 status,
  output logic             [deq_pkg::OCC_W-1:0]  occupancy
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = PW + 1;
  localparam int CMPW = (CW > 8) ? CW : 8;

  deq_pkg::state_t  state, state_next;
  deq_pkg::mode_t   cmd_mode;
  deq_pkg::mode_t   in_mode;
  deq_pkg::status_t acc_status;
  deq_pkg::status_t res_status;

  logic [PW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [PW-1:0] addr;
  logic [CW-1:0] idx;
  logic [deq_pkg::DATA_W-1:0] key;
  logic [deq_pkg::DATA_W-1:0] res_data;
  logic                       res_found;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic          pos_ok;
  logic [SW-1:0] offset;
  logic [SW-1:0] sum;
  logic [PW-1:0] slot;
  logic [PW-1:0] front_dec;
  logic [PW-1:0] front_inc;
  logic [PW-1:0] addr_inc;
  logic          out_load;
  logic          hit;

  logic                       mem_we;
  logic [PW-1:0]              mem_waddr;
  logic                       mem_re;
  logic [PW-1:0]              mem_raddr;
  logic [deq_pkg::DATA_W-1:0] mem_rdata;

  deq_ram #(
    .DEPTH(DEPTH),
    .AW   (PW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(data_in),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_mode  = deq_pkg::mode_t'(mode);
  assign in_stall = (state != deq_pkg::ST_IDLE);
  assign accept   = in_valid && (state == deq_pkg::ST_IDLE);
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign pos_ok   = (CMPW'(position) < CMPW'(count));
  assign out_load = (state == deq_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign hit      = (mem_rdata == key);

  always_comb begin
    case (in_mode)
      deq_pkg::MODE_PUSH_BACK: offset = SW'(count);
      deq_pkg::MODE_POP_BACK:  offset = SW'(count - 1'b1);
      deq_pkg::MODE_READ_AT,
      deq_pkg::MODE_WRITE_AT:  offset = SW'(position);
      default:                 offset = '0;
    endcase
    sum = SW'(front) + offset;
    if (sum >= SW'(DEPTH)) begin
      slot = PW'(sum - SW'(DEPTH));
    end else begin
      slot = PW'(sum);
    end
    front_dec = (front == '0) ? PW'(DEPTH - 1) : front - 1'b1;
    front_inc = (front == PW'(DEPTH - 1)) ? '0 : front + 1'b1;
    addr_inc  = (addr == PW'(DEPTH - 1)) ? '0 : addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    acc_status = deq_pkg::STAT_OK;
    front_next = front;
    count_next = count;
    mem_we     = 1'b0;
    mem_waddr  = slot;
    mem_re     = 1'b0;
    mem_raddr  = slot;
    case (state)
      deq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = deq_pkg::ST_DONE;
          case (in_mode)
            deq_pkg::MODE_PUSH_FRONT: begin
              if (is_full) begin
                acc_status = deq_pkg::STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = front_dec;
                front_next = front_dec;
                count_next = count + 1'b1;
              end
            end
            deq_pkg::MODE_PUSH_BACK: begin
              if (is_full) begin
                acc_status = deq_pkg::STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            deq_pkg::MODE_POP_FRONT: begin
              if (is_empty) begin
                acc_status = deq_pkg::STAT_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = front;
                front_next = front_inc;
                count_next = count - 1'b1;
                state_next = deq_pkg::ST_RD;
              end
            end
            deq_pkg::MODE_POP_BACK: begin
              if (is_empty) begin
                acc_status = deq_pkg::STAT_EMPTY;
              end else begin
                mem_re     = 1'b1;
                count_next = count - 1'b1;
                state_next = deq_pkg::ST_RD;
              end
            end
            deq_pkg::MODE_READ_AT: begin
              if (!pos_ok) begin
                acc_status = deq_pkg::STAT_RANGE;
              end else begin
                mem_re     = 1'b1;
                state_next = deq_pkg::ST_RD;
              end
            end
            deq_pkg::MODE_WRITE_AT: begin
              if (!pos_ok) begin
                acc_status = deq_pkg::STAT_RANGE;
              end else begin
                mem_we = 1'b1;
              end
            end
            deq_pkg::MODE_SEARCH: begin
              if (!is_empty) begin
                mem_re     = 1'b1;
                mem_raddr  = front;
                state_next = deq_pkg::ST_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      deq_pkg::ST_RD: begin
        state_next = deq_pkg::ST_DONE;
      end
      deq_pkg::ST_SRCH: begin
        mem_raddr = addr_inc;
        if (hit || (idx == count)) begin
          state_next = deq_pkg::ST_DONE;
        end else begin
          mem_re = 1'b1;
        end
      end
      deq_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode   <= in_mode;
      key        <= data_in;
      res_data   <= '0;
      res_found  <= 1'b0;
      res_status <= acc_status;
      addr       <= front;
      idx        <= CW'(1);
    end
    if (state == deq_pkg::ST_RD) begin
      res_data <= mem_rdata;
    end
    if (state == deq_pkg::ST_SRCH) begin
      if (hit) begin
        res_found <= 1'b1;
      end
      addr <= addr_inc;
      idx  <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      data_out  <= res_data;
      found     <= res_found;
      status    <= res_status;
      occupancy <= deq_pkg::OCC_W'(count);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_found_search: assert property (@(posedge clk) disable iff (rst)
    (state == deq_pkg::ST_DONE && res_found) |-> cmd_mode == deq_pkg::MODE_SEARCH)
    else $error("found set by a request other than search");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == deq_pkg::ST_DONE && res_status == deq_pkg::STAT_FULL) |-> is_full)
    else $error("full status with free entries");

  a_search_walk: assert property (@(posedge clk) disable iff (rst)
    state == deq_pkg::ST_SRCH |-> (idx <= count && idx != '0))
    else $error("search walked past the occupied entries");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (state != deq_pkg::ST_IDLE) |=> $stable(count) && $stable(front))
    else $error("pointers changed while a request was in flight");
`endif

endmodule
`default_nettype wire

// ===== src/deq_ram.sv =====
// Entry store: one write port, one read port, registered read data.
`default_nettype none
module deq_ram #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [deq_pkg::DATA_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr,
  output logic      [deq_pkg::DATA_W-1:0] rdata
);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the indexed deque engine: request driver, result monitor and deque predictor.
`timescale 1ns / 100ps
module tb_top;

  localparam int RING_SIZE = 256;
  localparam int RANDOM_REQS = 420;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    deq_pkg::mode_t     mode;
    logic [7:0]         pos;
    logic signed [31:0] data;
    bit                 drain;
    int                 gap;
  } deque_req_t;

  typedef struct {
    logic signed [31:0] data;
    logic               found;
    deq_pkg::status_t   status;
    logic [8:0]         occ;
  } deque_resp_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         mode = deq_pkg::MODE_NONE;
  logic [7:0]         position = '0;
  logic signed [31:0] data_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] data_out;
  logic               found;
  logic [1:0]         status;
  logic [8:0]         occupancy;

  deque_req_t  req_q[$];
  deque_resp_t resp_q[$];

  logic [31:0] ring_mem[RING_SIZE];
  logic [7:0]  ring_head = '0;
  logic [8:0]  ring_count = '0;

  int  gen_count = 0;
  bit  quiet_send = 1'b0;
  bit  quiet_recv = 1'b0;
  int  send_wait = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  int  errors = 0;
  logic [31:0] value_pool[8] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h1, 32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A};

  indexed_deque_engine_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .position (position),
    .data_in  (data_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data_out (data_out),
    .found    (found),
    .status   (status),
    .occupancy(occupancy)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic apply_request(input deq_pkg::mode_t m, input logic [7:0] pos,
                               input logic [31:0] val);
    deque_resp_t r;
    logic [7:0]  slot;
    r.data = '0;
    r.found = 1'b0;
    r.status = deq_pkg::STAT_OK;
    case (m)
      deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
        if (ring_count >= RING_SIZE) begin
          r.status = deq_pkg::STAT_FULL;
        end else begin
          if (m == deq_pkg::MODE_PUSH_FRONT) begin
            ring_head = ring_head - 8'd1;
            slot = ring_head;
          end else begin
            slot = ring_head + ring_count[7:0];
          end
          ring_mem[slot] = val;
          ring_count = ring_count + 9'd1;
        end
      end
      deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
        if (ring_count == 0) begin
          r.status = deq_pkg::STAT_EMPTY;
        end else begin
          if (m == deq_pkg::MODE_POP_FRONT) begin
            r.data = ring_mem[ring_head];
            ring_head = ring_head + 8'd1;
          end else begin
            slot = ring_head + ring_count[7:0] - 8'd1;
            r.data = ring_mem[slot];
          end
          ring_count = ring_count - 9'd1;
        end
      end
      deq_pkg::MODE_READ_AT, deq_pkg::MODE_WRITE_AT: begin
        if ({1'b0, pos} >= ring_count) begin
          r.status = deq_pkg::STAT_RANGE;
        end else begin
          slot = ring_head + pos;
          if (m == deq_pkg::MODE_READ_AT) r.data = ring_mem[slot];
          else ring_mem[slot] = val;
        end
      end
      deq_pkg::MODE_SEARCH: begin
        for (int i = 0; i < ring_count; i++) begin
          slot = ring_head + i[7:0];
          if (ring_mem[slot] == val) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.occ = ring_count;
    resp_q.push_back(r);
  endtask

  task automatic add_request(input deq_pkg::mode_t m, input logic [7:0] pos,
                             input logic [31:0] val, input bit drain);
    deque_req_t q;
    if ($urandom_range(0, 39) == 0) quiet_send = !quiet_send;
    q.mode = m;
    q.pos = pos;
    q.data = val;
    q.drain = drain;
    q.gap = quiet_send ? 0 : $urandom_range(0, 15);
    req_q.push_back(q);
    if ((m == deq_pkg::MODE_PUSH_FRONT || m == deq_pkg::MODE_PUSH_BACK) &&
        gen_count < RING_SIZE) gen_count++;
    if ((m == deq_pkg::MODE_POP_FRONT || m == deq_pkg::MODE_POP_BACK) &&
        gen_count > 0) gen_count--;
  endtask

  always @(posedge clk) begin : drv
    deque_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(deq_pkg::mode_t'(mode), position, data_in);
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0 && !(req_q[0].drain && resp_q.size() > 0)) begin
          nxt = req_q.pop_front();
          mode <= nxt.mode;
          position <= nxt.pos;
          data_in <= nxt.data;
          in_valid <= 1'b1;
          send_wait = nxt.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    deque_resp_t exp_r;
    int n;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      n = stall_left;
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected result data_out %h status %0d", $time, data_out, status);
          errors++;
        end else begin
          exp_r = resp_q.pop_front();
          if (data_out !== exp_r.data) begin
            $display("%0t: data_out expected %h actual %h", $time, exp_r.data, data_out);
            errors++;
          end
          if (found !== exp_r.found) begin
            $display("%0t: found expected %b actual %b", $time, exp_r.found, found);
            errors++;
          end
          if (status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
            errors++;
          end
          if (occupancy !== exp_r.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, exp_r.occ, occupancy);
            errors++;
          end
        end
        if ($urandom_range(0, 29) == 0) quiet_recv = !quiet_recv;
        n = quiet_recv ? 0 : $urandom_range(0, 15);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        stall_left = n - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left = 0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stim
    deq_pkg::mode_t m;
    logic [7:0]     p;
    logic [31:0]    v;
    int             r;
    int             full_hits;
    bit             filling;
    full_hits = 0;
    filling = 1'b1;

    // empty store: the empty and range errors, an empty search and the idle mode
    add_request(deq_pkg::MODE_POP_FRONT, 8'd0, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_POP_BACK, 8'd0, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_SEARCH, 8'd0, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_READ_AT, 8'd0, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_WRITE_AT, 8'd255, 32'hFFFF_FFFF, 1'b0);
    add_request(deq_pkg::MODE_NONE, 8'd255, 32'hFFFF_FFFF, 1'b0);
    // both ends, extreme values, head wrap
    add_request(deq_pkg::MODE_PUSH_BACK, 8'd0, 32'h7FFF_FFFF, 1'b0);
    add_request(deq_pkg::MODE_PUSH_FRONT, 8'd0, 32'h8000_0000, 1'b0);
    add_request(deq_pkg::MODE_PUSH_BACK, 8'd0, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_PUSH_FRONT, 8'd0, 32'hFFFF_FFFF, 1'b0);
    add_request(deq_pkg::MODE_READ_AT, 8'd0, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_READ_AT, 8'd3, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_READ_AT, 8'd4, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_READ_AT, 8'd255, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_WRITE_AT, 8'd3, 32'h5555_5555, 1'b1);
    add_request(deq_pkg::MODE_WRITE_AT, 8'd4, 32'hAAAA_AAAA, 1'b0);
    add_request(deq_pkg::MODE_SEARCH, 8'd0, 32'h8000_0000, 1'b0);
    add_request(deq_pkg::MODE_SEARCH, 8'd0, 32'h5555_5555, 1'b0);
    add_request(deq_pkg::MODE_SEARCH, 8'd0, 32'hAAAA_AAAA, 1'b0);
    add_request(deq_pkg::MODE_POP_BACK, 8'd0, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_POP_FRONT, 8'd0, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_NONE, 8'd0, 32'h0, 1'b0);
    add_request(deq_pkg::MODE_READ_AT, 8'd1, 32'h0, 1'b0);

    // fill to full, push against full, then mix everything
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (filling) begin
        if (gen_count == RING_SIZE) full_hits++;
        if (full_hits > 4) filling = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (filling && r < 88) m = r[0] ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK;
      else if (filling) m = deq_pkg::mode_t'($urandom_range(2, 7));
      else if (r < 5) m = deq_pkg::MODE_NONE;
      else m = deq_pkg::mode_t'($urandom_range(0, 6));
      if (gen_count > 0 && $urandom_range(0, 4) != 0) p = 8'($urandom_range(0, gen_count - 1));
      else p = 8'($urandom_range(0, 255));
      v = $urandom_range(0, 1) ? value_pool[3'($urandom_range(0, 7))] : $urandom;
      add_request(m, p, v, (n == 0) || ($urandom_range(0, 49) == 0));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() > 0 || in_valid || resp_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
